[rtl/spc_pkg.sv]
package spc_pkg;

  localparam int SAMPLE_INDEX_W = 12;
  localparam int RANGE_W        = 16;
  localparam int COORD_W        = 17;
  localparam int ANGLE_W        = 32;
  localparam int CORDIC_W       = 33;
  localparam int TRIG_W         = 16;
  localparam int PROD_W         = 33;
  localparam int CFG_INDEX_W    = 1;
  localparam int SHIFT_W        = 5;

  localparam int MAX_SAMPLES    = 4096;
  localparam int SINCOS_STAGES  = 16;
  localparam int ATAN_ENTRIES   = 24;
  localparam int CORDIC_CELLS   = (SINCOS_STAGES > ATAN_ENTRIES) ? ATAN_ENTRIES
                                                                 : SINCOS_STAGES;

  localparam logic signed [CORDIC_W-1:0] CORDIC_X0   = 33'sh026DD3B6A;
  localparam logic signed [CORDIC_W-1:0] TRIG_LIMIT  = 33'sd32767;
  localparam logic signed [PROD_W-1:0]   COORD_LIMIT = 33'sd65535;
  localparam logic signed [CORDIC_W-1:0] HALF_LSB_Q15 = 33'sd16384;
  localparam logic [ANGLE_W-1:0] QUARTER_TURN = 32'h4000_0000;
  localparam logic [ANGLE_W-1:0] HALF_TURN    = 32'h8000_0000;

  typedef enum logic [CFG_INDEX_W-1:0] {
    REG_ANGLE_START = 1'b0,
    REG_ANGLE_STEP  = 1'b1
  } cfg_reg_e;

  typedef logic [SHIFT_W-1:0] shift_t;

  typedef struct packed {
    logic signed [CORDIC_W-1:0] x;
    logic signed [CORDIC_W-1:0] y;
    logic signed [CORDIC_W-1:0] z;
    logic                       flip;
    logic [RANGE_W-1:0]         range;
    logic [SAMPLE_INDEX_W-1:0]  idx;
  } cell_data_t;

  // arctangent of 2^-i in binary-angle units
  function automatic logic signed [CORDIC_W-1:0] atan_of(input shift_t i);
    logic signed [CORDIC_W-1:0] a;
    case (i)
      5'd0:    a = 33'sh020000000;
      5'd1:    a = 33'sh012E4051E;
      5'd2:    a = 33'sh009FB385B;
      5'd3:    a = 33'sh0051111D4;
      5'd4:    a = 33'sh0028B0D43;
      5'd5:    a = 33'sh00145D7E1;
      5'd6:    a = 33'sh000A2F61E;
      5'd7:    a = 33'sh000517C55;
      5'd8:    a = 33'sh00028BE53;
      5'd9:    a = 33'sh000145F2F;
      5'd10:   a = 33'sh0000A2F98;
      5'd11:   a = 33'sh0000517CC;
      5'd12:   a = 33'sh000028BE6;
      5'd13:   a = 33'sh0000145F3;
      5'd14:   a = 33'sh00000A2FA;
      5'd15:   a = 33'sh00000517D;
      5'd16:   a = 33'sh0000028BE;
      5'd17:   a = 33'sh00000145F;
      5'd18:   a = 33'sh000000A30;
      5'd19:   a = 33'sh000000518;
      5'd20:   a = 33'sh00000028C;
      5'd21:   a = 33'sh000000146;
      5'd22:   a = 33'sh0000000A3;
      5'd23:   a = 33'sh000000051;
      default: a = '0;
    endcase
    return a;
  endfunction

endpackage

[rtl/spc_in_if.sv]
interface spc_in_if;
  logic                                valid;
  logic                                ready;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0]  sample_index;
  logic [spc_pkg::RANGE_W-1:0]         range_mm;
  logic                                range_valid;

  modport source (output valid, output sample_index, output range_mm,
                  output range_valid, input ready);
  modport sink   (input valid, input sample_index, input range_mm,
                  input range_valid, output ready);
endinterface

[rtl/spc_out_if.sv]
interface spc_out_if;
  logic                                valid;
  logic                                ready;
  logic signed [spc_pkg::COORD_W-1:0]  x_mm;
  logic signed [spc_pkg::COORD_W-1:0]  y_mm;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0]  point_index;

  modport source (output valid, output x_mm, output y_mm, output point_index,
                  input ready);
  modport sink   (input valid, input x_mm, input y_mm, input point_index,
                  output ready);
endinterface

[rtl/scan_polar_to_cartesian.sv]
// Lidar range sample to planar point.
// in_ch carries one sample per transaction (sample_index, range_mm,
// range_valid). Samples with range_valid low, or an index at or beyond the
// scan length, are taken and produce nothing. Every other sample gives one
// transaction on out_ch with x_mm = range*cos, y_mm = range*sin and the
// sample index, in the order the samples came in.
// Beam angle is angle_start + angle_step * index (binary angle, 2^32 a turn),
// set through cfg_wr_en / cfg_index / cfg_data; the user must write these
// only while the block is idle, as the block does not enforce this.
// Throughput: one sample per clock while out_ch is not stalled. Registered
// stages in order: step product, angle add and fold, one cell per CORDIC
// iteration, trig rounding, range product and coordinate rounding.
// Each stage holds its item until the next one is free, so while out_ch is
// stalled the pipeline keeps filling and in_ch.ready drops only once every
// stage is occupied.
// Synchronous reset empties the pipeline and clears both angle registers.
module scan_polar_to_cartesian (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_wr_en,
  input  logic [spc_pkg::CFG_INDEX_W-1:0]  cfg_index,
  input  logic [spc_pkg::ANGLE_W-1:0]      cfg_data,
  spc_in_if.sink                           in_ch,
  spc_out_if.source                        out_ch
);

  spc_pkg::cell_data_t chain_data  [0:spc_pkg::CORDIC_CELLS];
  logic                chain_valid [0:spc_pkg::CORDIC_CELLS];
  logic                chain_ready [0:spc_pkg::CORDIC_CELLS];

  spc_angle u_angle (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_wr_en (cfg_wr_en),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_ch     (in_ch),
    .data_o    (chain_data[0]),
    .valid_o   (chain_valid[0]),
    .ready_i   (chain_ready[0])
  );

  for (genvar k = 0; k < spc_pkg::CORDIC_CELLS; k++) begin : g_cell
    spc_cordic_cell u_cell (
      .clk     (clk),
      .rst_n   (rst_n),
      .shift_i (spc_pkg::shift_t'(k)),
      .data_i  (chain_data[k]),
      .valid_i (chain_valid[k]),
      .ready_o (chain_ready[k]),
      .data_o  (chain_data[k+1]),
      .valid_o (chain_valid[k+1]),
      .ready_i (chain_ready[k+1])
    );
  end

  spc_scale u_scale (
    .clk     (clk),
    .rst_n   (rst_n),
    .data_i  (chain_data[spc_pkg::CORDIC_CELLS]),
    .valid_i (chain_valid[spc_pkg::CORDIC_CELLS]),
    .ready_o (chain_ready[spc_pkg::CORDIC_CELLS]),
    .out_ch  (out_ch)
  );

endmodule

[rtl/spc_angle.sv]
module spc_angle (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_wr_en,
  input  logic [spc_pkg::CFG_INDEX_W-1:0]   cfg_index,
  input  logic [spc_pkg::ANGLE_W-1:0]       cfg_data,
  spc_in_if.sink                            in_ch,
  output spc_pkg::cell_data_t               data_o,
  output logic                              valid_o,
  input  logic                              ready_i
);

  logic [spc_pkg::ANGLE_W-1:0]        angle_start_r;
  logic [spc_pkg::ANGLE_W-1:0]        angle_step_r;

  logic                               prod_valid_r;
  logic [spc_pkg::ANGLE_W-1:0]        prod_r;
  logic [spc_pkg::RANGE_W-1:0]        range_r;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0] idx_r;
  logic                               prod_ready;
  logic                               keep;

  logic                               valid_r;
  spc_pkg::cell_data_t                data_r;
  spc_pkg::cell_data_t                data_nxt;
  logic [spc_pkg::ANGLE_W-1:0]        ang;
  logic [spc_pkg::ANGLE_W-1:0]        ang_folded;
  logic                               flip;
  logic                               out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      angle_start_r <= '0;
      angle_step_r  <= '0;
    end else if (cfg_wr_en) begin
      case (spc_pkg::cfg_reg_e'(cfg_index))
        spc_pkg::REG_ANGLE_START: angle_start_r <= cfg_data;
        spc_pkg::REG_ANGLE_STEP:  angle_step_r  <= cfg_data;
        default: ;
      endcase
    end
  end

  // dropped samples are taken but leave a bubble
  assign keep = in_ch.range_valid &&
                (32'(in_ch.sample_index) < 32'(spc_pkg::MAX_SAMPLES));

  assign out_ready   = !valid_r || ready_i;
  assign prod_ready  = !prod_valid_r || out_ready;
  assign in_ch.ready = prod_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      prod_valid_r <= 1'b0;
    end else if (prod_ready) begin
      prod_valid_r <= in_ch.valid && keep;
    end
  end

  always_ff @(posedge clk) begin
    if (prod_ready && in_ch.valid) begin
      prod_r  <= spc_pkg::ANGLE_W'(angle_step_r * in_ch.sample_index);
      range_r <= in_ch.range_mm;
      idx_r   <= in_ch.sample_index;
    end
  end

  // fold into the right half plane, negating both results later
  always_comb begin
    ang  = angle_start_r + prod_r;
    flip = ang[spc_pkg::ANGLE_W-1] ^ ang[spc_pkg::ANGLE_W-2];
    ang_folded = flip ? ang + spc_pkg::HALF_TURN : ang;
    data_nxt.x     = spc_pkg::CORDIC_X0;
    data_nxt.y     = '0;
    data_nxt.z     = spc_pkg::CORDIC_W'($signed(ang_folded));
    data_nxt.flip  = flip;
    data_nxt.range = range_r;
    data_nxt.idx   = idx_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (out_ready) begin
      valid_r <= prod_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (out_ready && prod_valid_r) begin
      data_r <= data_nxt;
    end
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

[rtl/spc_cordic_cell.sv]
module spc_cordic_cell (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spc_pkg::shift_t      shift_i,
  input  spc_pkg::cell_data_t  data_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  output spc_pkg::cell_data_t  data_o,
  output logic                 valid_o,
  input  logic                 ready_i
);

  logic                       valid_r;
  spc_pkg::cell_data_t        data_r;
  spc_pkg::cell_data_t        data_nxt;
  logic signed [spc_pkg::CORDIC_W-1:0] dx;
  logic signed [spc_pkg::CORDIC_W-1:0] dy;
  logic signed [spc_pkg::CORDIC_W-1:0] atan;

  always_comb begin
    dx   = data_i.y >>> shift_i;
    dy   = data_i.x >>> shift_i;
    atan = spc_pkg::atan_of(shift_i);
    data_nxt = data_i;
    if (!data_i.z[spc_pkg::CORDIC_W-1]) begin
      data_nxt.x = data_i.x - dx;
      data_nxt.y = data_i.y + dy;
      data_nxt.z = data_i.z - atan;
    end else begin
      data_nxt.x = data_i.x + dx;
      data_nxt.y = data_i.y - dy;
      data_nxt.z = data_i.z + atan;
    end
  end

  assign ready_o = !valid_r || ready_i;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (ready_o) begin
      valid_r <= valid_i;
    end
  end

  always_ff @(posedge clk) begin
    if (ready_o && valid_i) begin
      data_r <= data_nxt;
    end
  end

  assign data_o  = data_r;
  assign valid_o = valid_r;

endmodule

[rtl/spc_scale.sv]
module spc_scale (
  input  logic                 clk,
  input  logic                 rst_n,
  input  spc_pkg::cell_data_t  data_i,
  input  logic                 valid_i,
  output logic                 ready_o,
  spc_out_if.source            out_ch
);

  // trig rounding stage
  logic                               trig_valid_r;
  logic signed [spc_pkg::TRIG_W-1:0]  cos_r;
  logic signed [spc_pkg::TRIG_W-1:0]  sin_r;
  logic [spc_pkg::RANGE_W-1:0]        trig_range_r;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0] trig_idx_r;
  logic signed [spc_pkg::TRIG_W-1:0]  cos_nxt;
  logic signed [spc_pkg::TRIG_W-1:0]  sin_nxt;
  logic                               trig_ready;

  // product stage
  logic                               prod_valid_r;
  logic signed [spc_pkg::PROD_W-1:0]  px_r;
  logic signed [spc_pkg::PROD_W-1:0]  py_r;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0] prod_idx_r;
  logic                               prod_ready;

  // output stage
  logic                               out_valid_r;
  logic signed [spc_pkg::COORD_W-1:0] x_r;
  logic signed [spc_pkg::COORD_W-1:0] y_r;
  logic [spc_pkg::SAMPLE_INDEX_W-1:0] idx_r;
  logic                               out_stage_ready;

  function automatic logic signed [spc_pkg::TRIG_W-1:0] round_trig(
    input logic signed [spc_pkg::CORDIC_W-1:0] v,
    input logic                                neg
  );
    logic signed [spc_pkg::CORDIC_W-1:0] t;
    logic signed [spc_pkg::TRIG_W-1:0]   r;
    t = (v + spc_pkg::HALF_LSB_Q15) >>> 15;
    if (t > spc_pkg::TRIG_LIMIT) begin
      t = spc_pkg::TRIG_LIMIT;
    end else if (t < -spc_pkg::TRIG_LIMIT) begin
      t = -spc_pkg::TRIG_LIMIT;
    end
    r = t[spc_pkg::TRIG_W-1:0];
    return neg ? -r : r;
  endfunction

  function automatic logic signed [spc_pkg::COORD_W-1:0] round_coord(
    input logic signed [spc_pkg::PROD_W-1:0] p
  );
    logic signed [spc_pkg::PROD_W-1:0] t;
    t = (p + spc_pkg::PROD_W'(spc_pkg::HALF_LSB_Q15)) >>> 15;
    if (t > spc_pkg::COORD_LIMIT) begin
      t = spc_pkg::COORD_LIMIT;
    end else if (t < -spc_pkg::COORD_LIMIT) begin
      t = -spc_pkg::COORD_LIMIT;
    end
    return t[spc_pkg::COORD_W-1:0];
  endfunction

  assign cos_nxt = round_trig(data_i.x, data_i.flip);
  assign sin_nxt = round_trig(data_i.y, data_i.flip);

  assign out_stage_ready = !out_valid_r || out_ch.ready;
  assign prod_ready      = !prod_valid_r || out_stage_ready;
  assign trig_ready      = !trig_valid_r || prod_ready;
  assign ready_o         = trig_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      trig_valid_r <= 1'b0;
      prod_valid_r <= 1'b0;
      out_valid_r  <= 1'b0;
    end else begin
      if (trig_ready) begin
        trig_valid_r <= valid_i;
      end
      if (prod_ready) begin
        prod_valid_r <= trig_valid_r;
      end
      if (out_stage_ready) begin
        out_valid_r <= prod_valid_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (trig_ready && valid_i) begin
      cos_r        <= cos_nxt;
      sin_r        <= sin_nxt;
      trig_range_r <= data_i.range;
      trig_idx_r   <= data_i.idx;
    end
    if (prod_ready && trig_valid_r) begin
      px_r       <= $signed({1'b0, trig_range_r}) * cos_r;
      py_r       <= $signed({1'b0, trig_range_r}) * sin_r;
      prod_idx_r <= trig_idx_r;
    end
    if (out_stage_ready && prod_valid_r) begin
      x_r   <= round_coord(px_r);
      y_r   <= round_coord(py_r);
      idx_r <= prod_idx_r;
    end
  end

  assign out_ch.valid       = out_valid_r;
  assign out_ch.x_mm        = x_r;
  assign out_ch.y_mm        = y_r;
  assign out_ch.point_index = idx_r;

endmodule
